// File: rtl/core/ibm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibm_pkg: shared types and constants for the IoU best-match gate
// Box and command types, fixed widths and the beat layout of both streams.
// ----------------------------------------------------------------------------
package ibm_pkg;

    // Table size and coordinate width
    localparam int SLOTS        = 16;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int COORD_BITS   = 12;
    localparam int END_W        = COORD_BITS + 1;
    localparam int AREA_W       = 2 * COORD_BITS;
    localparam int UNI_W        = AREA_W + 1;
    localparam int PROD_W       = AREA_W + UNI_W;

    // Threshold register, units of 1/256
    localparam int THR_W        = 9;
    localparam int FRAC_BITS    = 8;
    localparam int SCALED_W     = AREA_W + FRAC_BITS;
    localparam int THR_PROD_W   = THR_W + UNI_W;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

    // Slot field width on both streams
    localparam int FIELD_SLOT_W = 4;

    // Input beat layout (tdata), lowest field first
    localparam int TD_SLOT_LSB   = 0;
    localparam int TD_LEFT_LSB   = TD_SLOT_LSB + FIELD_SLOT_W;
    localparam int TD_TOP_LSB    = TD_LEFT_LSB + COORD_BITS;
    localparam int TD_WIDTH_LSB  = TD_TOP_LSB + COORD_BITS;
    localparam int TD_HEIGHT_LSB = TD_WIDTH_LSB + COORD_BITS;
    localparam int TD_ACTIVE_BIT = TD_HEIGHT_LSB + COORD_BITS;
    localparam int S_TDATA_W     = ((TD_ACTIVE_BIT + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W     = 8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int Q_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Cycles from the last slot issue to its decision
    localparam int DRAIN_CYCLES = 5;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
    } box_t;

    typedef struct packed {
        op_t               op;
        logic              in_range;
        logic [SLOT_W-1:0] slot;
        box_t              box;
        logic              active;
    } cmd_t;

    // Packed so that the lowest bit is below_threshold
    typedef struct packed {
        logic [FIELD_SLOT_W-1:0] best_slot;
        logic                    any_match;
        logic                    below_threshold;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_THR,
        ST_DONE
    } back_state_t;

endpackage

// File: rtl/core/ibm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibm_front: input beat acceptance and classification
// Unpacks a beat, decodes the operation and the slot range check, and holds
// the classified command in a register until the queue takes it.
// ----------------------------------------------------------------------------
module ibm_front
    import ibm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // slot[3:0], box_left, box_top, box_width, box_height, slot_active, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic [0:0]           s_tuser,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd
);

    logic                    cmd_valid_reg;
    cmd_t                    cmd_reg;
    cmd_t                    cmd_next;
    logic [FIELD_SLOT_W-1:0] slot_fld;
    logic                    s_accept;

    // Take a beat when the holding register is empty or draining
    assign s_tready = !cmd_valid_reg || cmd_ready;
    assign s_accept = s_tvalid && s_tready;

    // Classify the beat
    always_comb
    begin
        slot_fld            = s_tdata[TD_SLOT_LSB +: FIELD_SLOT_W];
        cmd_next.op         = op_t'(s_tuser[0]);
        cmd_next.in_range   = ((SLOT_W + 1)'(slot_fld) < (SLOT_W + 1)'(SLOTS));
        cmd_next.slot       = slot_fld[SLOT_W-1:0];
        cmd_next.box.left   = s_tdata[TD_LEFT_LSB +: COORD_BITS];
        cmd_next.box.top    = s_tdata[TD_TOP_LSB +: COORD_BITS];
        cmd_next.box.width  = s_tdata[TD_WIDTH_LSB +: COORD_BITS];
        cmd_next.box.height = s_tdata[TD_HEIGHT_LSB +: COORD_BITS];
        cmd_next.active     = s_tdata[TD_ACTIVE_BIT];
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    // Capture the classified command
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

endmodule

// File: rtl/core/ibm_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibm_cmd_queue: short command queue between front and back
// Circular buffer of classified commands; the head is shown combinationally.
// ----------------------------------------------------------------------------
module ibm_cmd_queue
    import ibm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != Q_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= Q_PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= Q_PTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                count_reg <= Q_CNT_W'(count_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                count_reg <= Q_CNT_W'(count_reg - 1'b1);
            end
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/ibm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibm_back: box table and best-match walk
// Executes slot writes, walks the table for a query through an
// overlap/area/compare pipeline, applies the threshold and holds the result.
// ----------------------------------------------------------------------------
module ibm_back
    import ibm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    input  logic [THR_W-1:0] iou_threshold,
    output logic             m_tvalid,
    input  logic             m_tready,
    output res_t             result
);

    // Overlap length of [p1, p1+s1) and [p2, p2+s2), zero if none
    function automatic logic [COORD_BITS-1:0] span_overlap(
        input logic [COORD_BITS-1:0] p1,
        input logic [COORD_BITS-1:0] s1,
        input logic [COORD_BITS-1:0] p2,
        input logic [COORD_BITS-1:0] s2
    );
        logic [COORD_BITS-1:0] lo;
        logic [END_W-1:0]      e1;
        logic [END_W-1:0]      e2;
        logic [END_W-1:0]      hi;
        logic [END_W-1:0]      diff;
        lo   = (p1 > p2) ? p1 : p2;
        e1   = END_W'(p1) + END_W'(s1);
        e2   = END_W'(p2) + END_W'(s2);
        hi   = (e1 < e2) ? e1 : e2;
        diff = (hi > END_W'(lo)) ? (hi - END_W'(lo)) : '0;
        return diff[COORD_BITS-1:0];
    endfunction

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [SLOT_W-1:0]   idx_reg;
    logic [SLOT_W-1:0]   idx_next;
    logic [DRAIN_W-1:0]  drain_reg;
    logic [DRAIN_W-1:0]  drain_next;
    logic                pop;
    logic                out_free;
    logic                issue;

    // Table
    box_t                box_mem [SLOTS];
    logic [SLOTS-1:0]    active_reg;

    // Query
    box_t                q_reg;
    logic [AREA_W-1:0]   q_area_reg;

    // Pipeline stages
    logic                s1_vld_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    box_t                s1_box_reg;
    logic                s2_vld_reg;
    logic [SLOT_W-1:0]   s2_slot_reg;
    logic [COORD_BITS-1:0] s2_iw_reg;
    logic [COORD_BITS-1:0] s2_ih_reg;
    logic [COORD_BITS-1:0] s2_bw_reg;
    logic [COORD_BITS-1:0] s2_bh_reg;
    logic                s3_vld_reg;
    logic [SLOT_W-1:0]   s3_slot_reg;
    logic [AREA_W-1:0]   s3_inter_reg;
    logic [AREA_W-1:0]   s3_barea_reg;
    logic [UNI_W-1:0]    s4_uni_next;
    logic                s4_vld_reg;
    logic [SLOT_W-1:0]   s4_slot_reg;
    logic [AREA_W-1:0]   s4_inter_reg;
    logic [UNI_W-1:0]    s4_uni_reg;
    logic                s5_vld_reg;
    logic [SLOT_W-1:0]   s5_slot_reg;
    logic [AREA_W-1:0]   s5_inter_reg;
    logic [UNI_W-1:0]    s5_uni_reg;
    logic [PROD_W-1:0]   pb_lhs_reg;
    logic [PROD_W-1:0]   pb_rhs_reg;
    logic [PROD_W-1:0]   pf_lhs_reg;
    logic [PROD_W-1:0]   pf_rhs_reg;

    // Running best
    logic                found_reg;
    logic                prev_won_reg;
    logic [AREA_W-1:0]   best_i_reg;
    logic [UNI_W-1:0]    best_u_reg;
    logic [SLOT_W-1:0]   best_slot_reg;
    logic                less;
    logic                win;

    // Threshold and output
    logic [SCALED_W-1:0]   scaled_reg;
    logic [THR_PROD_W-1:0] thr_prod_reg;
    logic                  m_tvalid_reg;
    res_t                  res_reg;
    res_t                  res_next;

    assign out_free = !m_tvalid_reg || m_tready;
    assign pop      = cmd_valid && cmd_ready;
    assign issue    = (state_reg == ST_WALK);

    // Next state and pop control
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        drain_next = drain_reg;
        cmd_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid && (cmd.op == OP_QUERY))
                begin
                    state_next = ST_WALK;
                    idx_next   = '0;
                end
            end
            ST_WALK:
            begin
                idx_next = SLOT_W'(idx_reg + 1'b1);
                if (idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ST_DRAIN;
                    drain_next = '0;
                end
            end
            ST_DRAIN:
            begin
                drain_next = DRAIN_W'(drain_reg + 1'b1);
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1))
                begin
                    state_next = ST_THR;
                end
            end
            ST_THR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            drain_reg <= drain_next;
        end
    end

    // Active flags: write on a popped slot write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (pop && (cmd.op == OP_WRITE) && cmd.in_range)
        begin
            active_reg[cmd.slot] <= cmd.active;
        end
    end

    // Box store: write on a slot write, read one slot per walk cycle
    always_ff @(posedge clk)
    begin
        if (pop && (cmd.op == OP_WRITE) && cmd.in_range)
        begin
            box_mem[cmd.slot] <= cmd.box;
        end
        s1_box_reg <= box_mem[idx_reg];
    end

    // Latch the query box and its area
    always_ff @(posedge clk)
    begin
        if (pop && (cmd.op == OP_QUERY))
        begin
            q_reg <= cmd.box;
        end
        q_area_reg <= AREA_W'(q_reg.width) * AREA_W'(q_reg.height);
    end

    // Union of the candidate with the query
    assign s4_uni_next = UNI_W'(q_area_reg) + UNI_W'(s3_barea_reg) - UNI_W'(s3_inter_reg);

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= issue && active_reg[idx_reg];
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg && (s4_uni_next != '0);
            s5_vld_reg <= s4_vld_reg;
        end
    end

    // Stage payloads: overlap, areas, union, cross products
    always_ff @(posedge clk)
    begin
        s1_slot_reg  <= idx_reg;

        s2_slot_reg  <= s1_slot_reg;
        s2_iw_reg    <= span_overlap(q_reg.left, q_reg.width,
                                     s1_box_reg.left, s1_box_reg.width);
        s2_ih_reg    <= span_overlap(q_reg.top, q_reg.height,
                                     s1_box_reg.top, s1_box_reg.height);
        s2_bw_reg    <= s1_box_reg.width;
        s2_bh_reg    <= s1_box_reg.height;

        s3_slot_reg  <= s2_slot_reg;
        s3_inter_reg <= AREA_W'(s2_iw_reg) * AREA_W'(s2_ih_reg);
        s3_barea_reg <= AREA_W'(s2_bw_reg) * AREA_W'(s2_bh_reg);

        s4_slot_reg  <= s3_slot_reg;
        s4_inter_reg <= s3_inter_reg;
        s4_uni_reg   <= s4_uni_next;

        // Products against the stored best and, forwarded, against the
        // candidate deciding in this same cycle
        s5_slot_reg  <= s4_slot_reg;
        s5_inter_reg <= s4_inter_reg;
        s5_uni_reg   <= s4_uni_reg;
        pb_lhs_reg   <= PROD_W'(best_i_reg) * PROD_W'(s4_uni_reg);
        pb_rhs_reg   <= PROD_W'(s4_inter_reg) * PROD_W'(best_u_reg);
        pf_lhs_reg   <= PROD_W'(s5_inter_reg) * PROD_W'(s4_uni_reg);
        pf_rhs_reg   <= PROD_W'(s4_inter_reg) * PROD_W'(s5_uni_reg);
    end

    // Decide: the candidate beats the best when best_i/best_u < inter/uni
    assign less = prev_won_reg ? (pf_lhs_reg < pf_rhs_reg) : (pb_lhs_reg < pb_rhs_reg);
    assign win  = s5_vld_reg && (!found_reg || less);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            prev_won_reg <= 1'b0;
        end
        else if (pop && (cmd.op == OP_QUERY))
        begin
            found_reg    <= 1'b0;
            prev_won_reg <= 1'b0;
        end
        else
        begin
            found_reg    <= found_reg || win;
            prev_won_reg <= win;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win)
        begin
            best_i_reg    <= s5_inter_reg;
            best_u_reg    <= s5_uni_reg;
            best_slot_reg <= s5_slot_reg;
        end
    end

    // Scale the best ratio against the threshold
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_THR)
        begin
            scaled_reg   <= {best_i_reg, {FRAC_BITS{1'b0}}};
            thr_prod_reg <= THR_PROD_W'(iou_threshold) * THR_PROD_W'(best_u_reg);
        end
    end

    // Form the result
    always_comb
    begin
        if (found_reg)
        begin
            res_next.below_threshold = (THR_PROD_W'(scaled_reg) < thr_prod_reg);
            res_next.any_match       = 1'b1;
            res_next.best_slot       = FIELD_SLOT_W'(best_slot_reg);
        end
        else
        begin
            res_next.below_threshold = 1'b1;
            res_next.any_match       = 1'b0;
            res_next.best_slot       = '0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign result   = res_reg;

    // No-match results carry the fixed fill values
    a_nomatch_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && !res_reg.any_match |->
            res_reg.below_threshold && (res_reg.best_slot == '0))
        else $error("no-match result with non-default fields");

    // A first best is only recorded while the walk pipeline runs
    a_found_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(found_reg) |->
            ($past(state_reg) == ST_WALK) || ($past(state_reg) == ST_DRAIN))
        else $error("best updated outside the walk");

    // The pipeline is empty once the threshold step starts
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_THR) |-> !s4_vld_reg && !s5_vld_reg && !win)
        else $error("walk pipeline not drained before threshold");

    // A scoring slot never has a zero union
    a_best_union: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (best_u_reg != '0))
        else $error("best slot recorded with zero union");

endmodule

// File: rtl/core/iou_best_match_gate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iou_best_match_gate_top: IoU best-match gate over a table of boxes
// Front end, command queue, table/walk back end and the threshold register.
// ----------------------------------------------------------------------------
// A write beat (tuser 0) loads one table slot with a box and its active flag
// and returns nothing; a query beat (tuser 1) returns one result beat giving
// the active slot with the greatest intersection-over-union against the query
// box (first slot on ties), whether any slot scored, and whether that best
// IoU lies below iou_threshold/256. Beats are accepted one per cycle while the
// four-entry command queue has room. The back end takes one command at a time:
// for a query it walks the table one stored box per cycle through an overlap,
// area and cross-multiply pipeline, then forms the threshold product and the
// result. The threshold may be written only while no query is outstanding.
// ----------------------------------------------------------------------------
module iou_best_match_gate_top
    import ibm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [THR_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // slot[3:0], box_left, box_top, box_width, box_height, slot_active, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // below_threshold, any_match, best_slot[3:0], zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic             thr_reg;
    logic [THR_W-1:0] iou_threshold_reg;
    logic             f_valid;
    logic             f_ready;
    cmd_t             f_cmd;
    logic             b_valid;
    logic             b_ready;
    cmd_t             b_cmd;
    res_t             result;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iou_threshold_reg <= THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            iou_threshold_reg <= cfg_wr_data;
        end
    end

    // Flag a result beat waiting on the sink
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= 1'b0;
        end
        else
        begin
            thr_reg <= m_tvalid && !m_tready;
        end
    end

    ibm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    ibm_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_cmd    (b_cmd)
    );

    ibm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (b_valid),
        .cmd_ready     (b_ready),
        .cmd           (b_cmd),
        .iou_threshold (iou_threshold_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .result        (result)
    );

    // Pack the result beat
    assign m_tdata = M_TDATA_W'(result);

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        thr_reg |-> m_tvalid)
        else $error("result beat withdrawn while stalled");

endmodule
